// ===== rtl/core/smr_pkg.sv =====
// Shared types and constants for the selection mask raster unit.
// Depends on nothing; imported by the top level.
package smr_pkg;

  // Configuration register width and indexes
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 1'b1;

  // Command field widths
  localparam int REQ_W    = 2;
  localparam int COORD_W  = 8;
  localparam int RADIUS_W = 9;

  // Command codes
  localparam logic [REQ_W-1:0] REQ_BOX    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_CIRCLE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ   = 2'd2;

  // Signed pixel coordinate, covers centre +/- radius
  typedef logic signed [10:0] coord_t;
  // Signed decision variable of the circle stepper
  typedef logic signed [11:0] dist_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_BOX,
    S_CIRC,
    S_READ,
    S_RESULT
  } state_e;

endpackage

// ===== rtl/core/smr_ram.sv =====
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
module smr_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write or read one entry per cycle
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/selection_mask_raster_unit.sv =====
// Selection mask raster unit: box fill, circle outline and bit read on a 1-bit mask.
// Depends on smr_pkg and smr_ram.
//
// The mask lives in one single-port RAM of MAX_WIDTH*MAX_HEIGHT bits, and all
// timing follows from that port handling one pixel per cycle. After reset the
// unit clears the mask, writing every entry once, and takes no command during
// that pass; configuration writes are taken at any time. A box command writes
// every pixel of its rectangle, including pixels outside the image, which are
// dropped at the range check; an empty box goes straight to the result. A
// circle command writes eight points per step of the outline; a negative
// radius goes straight to the result. A read command returns one mask bit,
// 0 outside the image. Every command returns exactly one result transaction;
// read_bit is 0 for everything but a read. The result sits in an output
// register, so the next command is taken while it waits.
module selection_mask_raster_unit #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration
  input  logic                           cfg_we_i,
  input  logic [smr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [smr_pkg::CFG_W-1:0]      cfg_data_i,
  // command channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [smr_pkg::REQ_W-1:0]      req_type_i,
  input  logic [smr_pkg::COORD_W-1:0]    x_first_i,
  input  logic [smr_pkg::COORD_W-1:0]    y_first_i,
  input  logic [smr_pkg::COORD_W-1:0]    x_last_i,
  input  logic [smr_pkg::COORD_W-1:0]    y_last_i,
  input  logic signed [smr_pkg::RADIUS_W-1:0] radius_i,
  input  logic                           mark_i,
  // result channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           read_bit_o
);

  import smr_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);

  // ---------------------------------------------------------------------------
  // Configuration registers and effective image size
  logic [CFG_W-1:0] cfg_width_q, cfg_height_q;
  logic [CFG_W-1:0] eff_w, eff_h;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q  <= CFG_W'(256);
      cfg_height_q <= CFG_W'(256);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_IDX_WIDTH:  cfg_width_q  <= cfg_data_i;
        CFG_IDX_HEIGHT: cfg_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign eff_w = (int'(cfg_width_q) > MAX_WIDTH)   ? CFG_W'(MAX_WIDTH)  : cfg_width_q;
  assign eff_h = (int'(cfg_height_q) > MAX_HEIGHT) ? CFG_W'(MAX_HEIGHT) : cfg_height_q;

  // ---------------------------------------------------------------------------
  // Control state
  state_e               state_q, state_d;
  logic [AW-1:0]        clr_cnt_q, clr_cnt_d;
  logic [COORD_W-1:0]   xa_q, xa_d, ya_q, ya_d;   // box origin or circle centre
  logic [COORD_W-1:0]   xb_q, xb_d, yb_q, yb_d;   // box far corner
  logic [COORD_W-1:0]   bx_q, bx_d, by_q, by_d;   // box scan position
  logic [COORD_W-1:0]   r_q, r_d;
  coord_t               ox_q, ox_d, oy_q, oy_d;
  dist_t                d_q, d_d;
  logic [2:0]           pt_q, pt_d;
  logic                 mark_q, mark_d;
  logic                 res_bit_q, res_bit_d;
  logic                 out_valid_q, out_valid_d;
  logic                 out_bit_q, out_bit_d;

  // pixel generator output register
  logic                 pix_vld_q, pix_vld_d;
  logic                 pix_rd_q, pix_rd_d;
  logic                 pix_mark_q, pix_mark_d;
  coord_t               pix_x_q, pix_x_d, pix_y_q, pix_y_d;

  // range check and row offset stage
  logic                 s1_vld_q, s1_rd_q, s1_ok_q, s1_mark_q;
  logic [2*CFG_W-1:0]   s1_prod_q;
  logic [CFG_W-1:0]     s1_x_q;

  // read return
  logic                 rd_pend_q, rd_ok_q;
  logic                 ram_rdata;

  // circle stepper arithmetic
  dist_t                ox_w, oy_w, r_w, two_x;
  coord_t               dx, dy, cx_w, cy_w;

  assign ox_w  = dist_t'(ox_q);
  assign oy_w  = dist_t'(oy_q);
  assign r_w   = dist_t'({4'b0, r_q});
  assign two_x = ox_w + ox_w;
  assign dx    = pt_q[0] ? oy_q : ox_q;
  assign dy    = pt_q[0] ? ox_q : oy_q;
  assign cx_w  = coord_t'({3'b0, xa_q});
  assign cy_w  = coord_t'({3'b0, ya_q});

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      pix_vld_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      out_valid_q <= out_valid_d;
      pix_vld_q   <= pix_vld_d;
    end
  end

  // Command registers
  always_ff @(posedge clk_i) begin
    xa_q       <= xa_d;
    ya_q       <= ya_d;
    xb_q       <= xb_d;
    yb_q       <= yb_d;
    bx_q       <= bx_d;
    by_q       <= by_d;
    r_q        <= r_d;
    ox_q       <= ox_d;
    oy_q       <= oy_d;
    d_q        <= d_d;
    pt_q       <= pt_d;
    mark_q     <= mark_d;
    res_bit_q  <= res_bit_d;
    out_bit_q  <= out_bit_d;
    pix_rd_q   <= pix_rd_d;
    pix_mark_q <= pix_mark_d;
    pix_x_q    <= pix_x_d;
    pix_y_q    <= pix_y_d;
  end

  // Next state, pixel generation and result handling
  always_comb begin
    state_d     = state_q;
    clr_cnt_d   = clr_cnt_q;
    xa_d        = xa_q;
    ya_d        = ya_q;
    xb_d        = xb_q;
    yb_d        = yb_q;
    bx_d        = bx_q;
    by_d        = by_q;
    r_d         = r_q;
    ox_d        = ox_q;
    oy_d        = oy_q;
    d_d         = d_q;
    pt_d        = pt_q;
    mark_d      = mark_q;
    res_bit_d   = res_bit_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_bit_d   = out_bit_q;
    pix_vld_d   = 1'b0;
    pix_rd_d    = 1'b0;
    pix_mark_d  = mark_q;
    pix_x_d     = pix_x_q;
    pix_y_d     = pix_y_q;
    in_stall_o  = 1'b1;

    unique case (state_q)
      S_CLEAR: begin
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == AW'(DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          xa_d      = x_first_i;
          ya_d      = y_first_i;
          xb_d      = x_last_i;
          yb_d      = y_last_i;
          bx_d      = x_first_i;
          by_d      = y_first_i;
          r_d       = radius_i[COORD_W-1:0];
          ox_d      = '0;
          oy_d      = coord_t'({3'b0, radius_i[COORD_W-1:0]});
          d_d       = dist_t'({4'b0, radius_i[COORD_W-1:0]}) - dist_t'(1);
          pt_d      = '0;
          mark_d    = mark_i;
          res_bit_d = 1'b0;
          case (req_type_i)
            REQ_BOX: begin
              if (x_first_i > x_last_i || y_first_i > y_last_i) begin
                state_d = S_RESULT;
              end else begin
                state_d = S_BOX;
              end
            end
            REQ_CIRCLE: begin
              state_d = radius_i[RADIUS_W-1] ? S_RESULT : S_CIRC;
            end
            REQ_READ: begin
              pix_vld_d = 1'b1;
              pix_rd_d  = 1'b1;
              pix_x_d   = coord_t'({3'b0, x_first_i});
              pix_y_d   = coord_t'({3'b0, y_first_i});
              state_d   = S_READ;
            end
            default: state_d = S_RESULT;
          endcase
        end
      end

      // Row-major scan of the rectangle, one pixel per cycle
      S_BOX: begin
        pix_vld_d = 1'b1;
        pix_x_d   = coord_t'({3'b0, bx_q});
        pix_y_d   = coord_t'({3'b0, by_q});
        if (bx_q == xb_q) begin
          bx_d = xa_q;
          by_d = by_q + 1'b1;
          if (by_q == yb_q) begin
            state_d = S_RESULT;
          end
        end else begin
          bx_d = bx_q + 1'b1;
        end
      end

      // Eight symmetric points per step, then one decision update
      S_CIRC: begin
        if (pt_q == 3'd0 && ox_q > oy_q) begin
          state_d = S_RESULT;
        end else begin
          pix_vld_d = 1'b1;
          pix_x_d   = pt_q[1] ? (cx_w - dx) : (cx_w + dx);
          pix_y_d   = pt_q[2] ? (cy_w - dy) : (cy_w + dy);
          pt_d      = pt_q + 1'b1;
          if (pt_q == 3'd7) begin
            if (d_q >= two_x) begin
              d_d  = d_q - two_x - dist_t'(1);
              ox_d = ox_q + coord_t'(1);
            end else if (d_q < ((r_w - oy_w) + (r_w - oy_w))) begin
              d_d  = d_q + oy_w + oy_w - dist_t'(1);
              oy_d = oy_q - coord_t'(1);
            end else begin
              d_d  = d_q + ((oy_w - ox_w - dist_t'(1)) + (oy_w - ox_w - dist_t'(1)));
              oy_d = oy_q - coord_t'(1);
              ox_d = ox_q + coord_t'(1);
            end
          end
        end
      end

      S_READ: begin
        if (rd_pend_q) begin
          res_bit_d = rd_ok_q & ram_rdata;
          state_d   = S_RESULT;
        end
      end

      S_RESULT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_bit_d   = res_bit_q;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Range check and row offset; writes outside the image are dropped here
  logic pix_ok;

  assign pix_ok = (pix_x_q >= 0) && (pix_y_q >= 0) &&
                  (pix_x_q < $signed({2'b00, eff_w})) &&
                  (pix_y_q < $signed({2'b00, eff_h}));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      rd_pend_q <= 1'b0;
    end else begin
      s1_vld_q  <= pix_vld_q;
      rd_pend_q <= s1_vld_q && s1_rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_rd_q   <= pix_rd_q;
    s1_ok_q   <= pix_ok;
    s1_mark_q <= pix_mark_q;
    s1_prod_q <= pix_y_q[CFG_W-1:0] * eff_w;
    s1_x_q    <= pix_x_q[CFG_W-1:0];
    rd_ok_q   <= s1_ok_q;
  end

  // ---------------------------------------------------------------------------
  // Mask memory port: clearing pass, else the pixel pipeline
  logic          ram_en, ram_we, ram_wdata;
  logic [AW-1:0] ram_addr;

  always_comb begin
    if (state_q == S_CLEAR) begin
      ram_en    = 1'b1;
      ram_we    = 1'b1;
      ram_addr  = clr_cnt_q;
      ram_wdata = 1'b0;
    end else begin
      ram_en    = s1_vld_q && s1_ok_q;
      ram_we    = !s1_rd_q;
      ram_addr  = AW'(s1_prod_q) + AW'(s1_x_q);
      ram_wdata = s1_mark_q;
    end
  end

  smr_ram #(
    .WIDTH (1),
    .DEPTH (DEPTH)
  ) u_mask_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign read_bit_o  = out_bit_q;

endmodule
